// ===== rtl/core/mfd_pkg.sv =====
`timescale 1ns / 1ps
package mfd_pkg;

	localparam int NUM_SLOTS = 6;

	localparam int ID_W   = 11;
	localparam int LEN_W  = 4;
	localparam int KIND_W = 5;
	localparam int SLOT_W = 3;
	localparam int STAT_W = 3;
	localparam int STEP_W = 3;
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 40;

	localparam logic [ID_W-1:0] REPLY_ID  = 11'h7FF;
	localparam logic [ID_W-1:0] AUTO_BASE = 11'h205;

	localparam logic [1:0] MODE_RESP = 2'd0;
	localparam logic [1:0] MODE_AUTO = 2'd1;

	localparam logic [KIND_W-1:0] K_NONE     = 5'd0;
	localparam logic [KIND_W-1:0] K_MOTOR_ID = 5'd1;
	localparam logic [KIND_W-1:0] K_ERROR    = 5'd2;
	localparam logic [KIND_W-1:0] K_POS_RAW  = 5'd3;
	localparam logic [KIND_W-1:0] K_SPD_RAW  = 5'd4;
	localparam logic [KIND_W-1:0] K_CUR_RAW  = 5'd5;
	localparam logic [KIND_W-1:0] K_TEMP     = 5'd6;
	localparam logic [KIND_W-1:0] K_ANGLE_F  = 5'd7;
	localparam logic [KIND_W-1:0] K_CUR_INT  = 5'd8;
	localparam logic [KIND_W-1:0] K_SPEED_F  = 5'd9;
	localparam logic [KIND_W-1:0] K_CUR_F    = 5'd10;
	localparam logic [KIND_W-1:0] K_POWER_F  = 5'd11;
	localparam logic [KIND_W-1:0] K_AUTO_ANG = 5'd17;
	localparam logic [KIND_W-1:0] K_AUTO_SPD = 5'd18;
	localparam logic [KIND_W-1:0] K_FB_ID    = 5'd19;
	localparam logic [KIND_W-1:0] K_FB_CODE  = 5'd20;
	localparam logic [KIND_W-1:0] K_INSTR    = 5'd21;

	localparam logic [STAT_W-1:0] ST_WRITTEN = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STAT_W-1:0] ST_SKIPPED = 3'd2;
	localparam logic [STAT_W-1:0] ST_RAISED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NONE    = 3'd5;

	localparam logic [7:0] REPLY_OK   = 8'h01;
	localparam logic [7:0] FB_CODE_FF = 8'h06;
	localparam logic [7:0] FB_CODE_80 = 8'h80;
	localparam logic [7:0] FB_CODE_7F = 8'h05;

	typedef enum logic [3:0] {
		CL_SKIPPED,
		CL_EMPTY,
		CL_RAISED,
		CL_NO_DECODE,
		CL_REPLY,
		CL_ACK_ID,
		CL_ACK1,
		CL_ACK23,
		CL_ACK4_BAD,
		CL_ACK4,
		CL_ACK5,
		CL_AUTO
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [STEP_W-1:0] last_step;
		logic              ok;
		logic [SLOT_W-1:0] idx;
		logic              sel;
		logic [ID_W-1:0]   id;
		logic [7:0][7:0]   d;
		logic [KIND_W-1:0] xkind;
		logic [7:0]        xcode;
		logic [31:0]       xval;
	} rec_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       value;
		logic              sel;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

// ===== rtl/core/motor_feedback_frame_decoder_core.sv =====
`timescale 1ns / 1ps
// motor feedback frame decoder
// input stream: one bus frame per word, s_tuser marks the first frame of a
// message; output stream: one record write per word, m_tlast on the final
// write of a frame, m_tuser carries the written field kind
// cfg_wen/cfg_wdata write the communication mode; the user is to write it
// only while idle, the block does not enforce this
// a classifier takes a frame into a two-entry queue in the cycle it arrives;
// a sequencer then emits the frame's writes one per cycle from the queue head
// while the output is not stalled; the first write of a frame passes through
// the queue and then the output register; a frame has 1 to 6 writes, set by
// the sequencer stepping through its writes; frames are taken back to back
// while the queue has room
// when m_tready is low the output register holds its word, the sequencer
// waits and the queue fills, after which s_tready drops
// reset clears the mode to response mode, the skip flag, the queue and the
// output valid
module motor_feedback_frame_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [1:0]                    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// frame_id, frame_length, byte0 .. byte7, zero pad
	input  logic [mfd_pkg::S_DATA_W-1:0]  s_tdata,
	// start_of_message
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// slot, value, scale_select, status, zero pad
	output logic [mfd_pkg::M_DATA_W-1:0]  m_tdata,
	// kind
	output logic [mfd_pkg::KIND_W-1:0]    m_tuser,
	output logic                          m_tlast
);

	mfd_pkg::rec_t  f_rec;
	mfd_pkg::rec_t  q_rec;
	logic           q_push;
	logic           q_full;
	logic           q_nempty;
	logic           q_pop;

	mfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (q_push),
		.rec       (f_rec)
	);

	mfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_rec    (f_rec),
		.pop       (q_pop),
		.not_empty (q_nempty),
		.full      (q_full),
		.rd_rec    (q_rec)
	);

	mfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_nempty),
		.rec      (q_rec),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/mfd_front.sv =====
`timescale 1ns / 1ps
module mfd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [1:0]                    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mfd_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	input  logic                          q_full,
	output logic                          push,
	output mfd_pkg::rec_t                 rec
);

	localparam logic [mfd_pkg::ID_W-1:0] NSLOT = mfd_pkg::ID_W'(mfd_pkg::NUM_SLOTS);

	logic [1:0] mode_q;
	logic       skip_q;

	logic [mfd_pkg::ID_W-1:0]  id;
	logic [mfd_pkg::LEN_W-1:0] len;
	logic [7:0][7:0]           d;
	logic [2:0]                ack;
	logic                      sk_eff;
	logic                      skip_nx;
	logic [mfd_pkg::ID_W-1:0]  id_r;
	logic [mfd_pkg::ID_W-1:0]  id_a;
	logic                      ok_r;
	logic                      ok_a;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		id  = s_tdata[10:0];
		len = s_tdata[14:11];
		for (int i = 0; i < 8; i++) begin
			d[i] = s_tdata[15 + 8*i +: 8];
		end
		ack    = d[0][7:5];
		sk_eff = s_tuser ? 1'b0 : skip_q;
		id_r   = id - 11'd1;
		id_a   = id - mfd_pkg::AUTO_BASE;
		ok_r   = (id != 11'd0) && (id_r < NSLOT);
		ok_a   = (id >= mfd_pkg::AUTO_BASE) && (id_a < NSLOT);

		rec           = '0;
		rec.id        = id;
		rec.d         = d;
		rec.sel       = (id == 11'd3) || (id == 11'd4);
		rec.ok        = (mode_q == mfd_pkg::MODE_AUTO) ? ok_a : ok_r;
		rec.idx       = (mode_q == mfd_pkg::MODE_AUTO) ? id_a[2:0] : id_r[2:0];
		rec.cls       = mfd_pkg::CL_NO_DECODE;
		rec.last_step = 3'd0;
		skip_nx       = sk_eff;

		if (sk_eff) begin
			rec.cls = mfd_pkg::CL_SKIPPED;
		end else if (len == 4'd0) begin
			rec.cls = mfd_pkg::CL_EMPTY;
		end else if (id == mfd_pkg::REPLY_ID) begin
			if (d[2] != mfd_pkg::REPLY_OK) begin
				rec.cls = mfd_pkg::CL_RAISED;
				skip_nx = 1'b1;
			end else begin
				rec.cls       = mfd_pkg::CL_REPLY;
				rec.last_step = 3'd1;
				if (d[0] == 8'hFF && d[1] == 8'hFF) begin
					rec.xval  = {16'd0, d[3], d[4]};
					rec.xcode = mfd_pkg::FB_CODE_FF;
				end else if (d[0] == 8'h80 && d[1] == 8'h80) begin
					rec.xval  = 32'd0;
					rec.xcode = mfd_pkg::FB_CODE_80;
				end else if (d[0] == 8'h7F && d[1] == 8'h7F) begin
					rec.xval  = 32'd1;
					rec.xcode = mfd_pkg::FB_CODE_7F;
				end else begin
					rec.xval  = {16'd0, d[0], d[1]};
					rec.xcode = d[3];
				end
			end
		end else if (mode_q == mfd_pkg::MODE_RESP) begin
			case (ack)
				3'd1: begin
					rec.cls       = mfd_pkg::CL_ACK1;
					rec.last_step = 3'd5;
				end
				3'd2, 3'd3: begin
					rec.cls       = mfd_pkg::CL_ACK23;
					rec.last_step = 3'd4;
					rec.xkind     = (ack == 3'd2) ? mfd_pkg::K_ANGLE_F : mfd_pkg::K_SPEED_F;
					rec.xval      = {d[1], d[2], d[3], d[4]};
				end
				3'd4: begin
					if (len != 4'd3) begin
						rec.cls       = mfd_pkg::CL_ACK4_BAD;
						rec.last_step = 3'd2;
						skip_nx       = 1'b1;
					end else begin
						rec.cls       = mfd_pkg::CL_ACK4;
						rec.last_step = 3'd3;
					end
				end
				3'd5: begin
					rec.cls       = mfd_pkg::CL_ACK5;
					rec.last_step = 3'd2;
					if (d[1] >= 8'd1 && d[1] <= 8'd4 && len == 4'd6) begin
						rec.last_step = 3'd3;
						rec.xval      = {d[2], d[3], d[4], d[5]};
						case (d[1][2:0])
							3'd1:    rec.xkind = mfd_pkg::K_ANGLE_F;
							3'd2:    rec.xkind = mfd_pkg::K_SPEED_F;
							3'd3:    rec.xkind = mfd_pkg::K_CUR_F;
							default: rec.xkind = mfd_pkg::K_POWER_F;
						endcase
					end else if (d[1] >= 8'd5 && d[1] <= 8'd9 && len == 4'd4) begin
						rec.last_step = 3'd3;
						rec.xval      = {16'd0, d[2], d[3]};
						rec.xkind     = d[1][4:0] + 5'd7;
					end
				end
				default: begin
					rec.cls       = mfd_pkg::CL_ACK_ID;
					rec.last_step = 3'd1;
				end
			endcase
		end else if (mode_q == mfd_pkg::MODE_AUTO) begin
			rec.cls       = mfd_pkg::CL_AUTO;
			rec.last_step = 3'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mfd_pkg::MODE_RESP;
			skip_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end
			if (push) begin
				skip_q <= skip_nx;
			end
		end
	end

endmodule

// ===== rtl/core/mfd_queue.sv =====
`timescale 1ns / 1ps
module mfd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfd_pkg::rec_t  wr_rec,
	input  logic           pop,
	output logic           not_empty,
	output logic           full,
	output mfd_pkg::rec_t  rd_rec
);

	mfd_pkg::rec_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'd2;
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/mfd_back.sv =====
`timescale 1ns / 1ps
module mfd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  mfd_pkg::rec_t                 rec,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mfd_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [mfd_pkg::KIND_W-1:0]    m_tuser,
	output logic                          m_tlast
);

	logic [mfd_pkg::STEP_W-1:0] step_q;
	logic                       ovalid_q;
	logic                       olast_q;
	mfd_pkg::res_t              ores_q;
	mfd_pkg::res_t              res;
	logic                       adv;
	logic                       at_last;

	function automatic mfd_pkg::res_t wr_slot(mfd_pkg::rec_t r, logic [4:0] k,
			logic [31:0] v);
		mfd_pkg::res_t o;
		o.kind   = k;
		o.value  = v;
		o.sel    = r.sel;
		o.slot   = r.ok ? r.idx : 3'd0;
		o.status = r.ok ? mfd_pkg::ST_WRITTEN : mfd_pkg::ST_RANGE;
		return o;
	endfunction

	function automatic mfd_pkg::res_t wr_plain(logic [4:0] k, logic [31:0] v);
		mfd_pkg::res_t o;
		o        = '0;
		o.kind   = k;
		o.value  = v;
		o.status = mfd_pkg::ST_WRITTEN;
		return o;
	endfunction

	function automatic mfd_pkg::res_t st_only(logic [2:0] s);
		mfd_pkg::res_t o;
		o        = '0;
		o.status = s;
		return o;
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] temp_of(logic [7:0] b);
		logic [8:0] t;
		logic [8:0] s;
		t = {1'b0, b} - 9'd50;
		s = t + {8'd0, t[8]};
		return {{24{s[8]}}, s[8:1]};
	endfunction

	function automatic mfd_pkg::res_t gen(mfd_pkg::rec_t r, logic [2:0] st);
		mfd_pkg::res_t o;
		o = '0;
		case (r.cls)
			mfd_pkg::CL_SKIPPED:   o = st_only(mfd_pkg::ST_SKIPPED);
			mfd_pkg::CL_EMPTY:     o = st_only(mfd_pkg::ST_EMPTY);
			mfd_pkg::CL_RAISED:    o = st_only(mfd_pkg::ST_RAISED);
			mfd_pkg::CL_NO_DECODE: o = st_only(mfd_pkg::ST_NONE);
			mfd_pkg::CL_REPLY: begin
				o = (st == 3'd0) ? wr_plain(mfd_pkg::K_FB_ID, r.xval)
				                 : wr_plain(mfd_pkg::K_FB_CODE, {24'd0, r.xcode});
			end
			mfd_pkg::CL_AUTO: begin
				case (st)
					3'd0:    o = wr_slot(r, mfd_pkg::K_MOTOR_ID, {21'd0, r.id});
					3'd1:    o = wr_slot(r, mfd_pkg::K_AUTO_ANG, {16'd0, r.d[0], r.d[1]});
					3'd2:    o = wr_slot(r, mfd_pkg::K_AUTO_SPD, sx16({r.d[2], r.d[3]}));
					3'd3:    o = wr_slot(r, mfd_pkg::K_CUR_INT, sx16({r.d[4], r.d[5]}));
					3'd4:    o = wr_slot(r, mfd_pkg::K_TEMP, {24'd0, r.d[6]});
					default: o = wr_slot(r, mfd_pkg::K_ERROR, {24'd0, r.d[7]});
				endcase
			end
			default: begin
				// response mode frames: motor id and error come first
				if (st == 3'd0) begin
					o = wr_slot(r, mfd_pkg::K_MOTOR_ID, {21'd0, r.id});
				end else if (st == 3'd1) begin
					o = wr_slot(r, mfd_pkg::K_ERROR, {27'd0, r.d[0][4:0]});
				end else begin
					case (r.cls)
						mfd_pkg::CL_ACK1: begin
							case (st)
								3'd2:    o = wr_slot(r, mfd_pkg::K_POS_RAW,
								                     {16'd0, r.d[1], r.d[2]});
								3'd3:    o = wr_slot(r, mfd_pkg::K_SPD_RAW,
								                     {20'd0, r.d[3], r.d[4][7:4]});
								3'd4:    o = wr_slot(r, mfd_pkg::K_CUR_RAW,
								                     {20'd0, r.d[4][3:0], r.d[5]});
								default: o = wr_slot(r, mfd_pkg::K_TEMP, temp_of(r.d[6]));
							endcase
						end
						mfd_pkg::CL_ACK23: begin
							case (st)
								3'd2:    o = wr_slot(r, r.xkind, r.xval);
								3'd3:    o = wr_slot(r, mfd_pkg::K_CUR_INT,
								                     sx16({r.d[5], r.d[6]}));
								default: o = wr_slot(r, mfd_pkg::K_TEMP, temp_of(r.d[7]));
							endcase
						end
						mfd_pkg::CL_ACK4_BAD: o = st_only(mfd_pkg::ST_RAISED);
						mfd_pkg::CL_ACK4: begin
							o = (st == 3'd2) ? wr_plain(mfd_pkg::K_INSTR, {24'd0, r.d[1]})
							                 : wr_plain(mfd_pkg::K_FB_CODE, {24'd0, r.d[2]});
						end
						mfd_pkg::CL_ACK5: begin
							o = (st == 3'd2) ? wr_plain(mfd_pkg::K_INSTR, {24'd0, r.d[1]})
							                 : wr_slot(r, r.xkind, r.xval);
						end
						default: o = '0;
					endcase
				end
			end
		endcase
		return o;
	endfunction

	assign res     = gen(rec, step_q);
	assign at_last = step_q == rec.last_step;
	assign adv     = q_valid && (!ovalid_q || m_tready);
	assign pop     = adv && at_last;

	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tuser  = ores_q.kind;
	assign m_tdata  = {1'b0, ores_q.status, ores_q.sel, ores_q.value, ores_q.slot};

	always_ff @(posedge clk) begin
		if (adv) begin
			ores_q  <= res;
			olast_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv) begin
				ovalid_q <= 1'b1;
				step_q   <= at_last ? '0 : step_q + 3'd1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/mfd_checker.sv =====
`timescale 1ns / 1ps
module mfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_wen,
	input logic [1:0]                    cfg_wdata,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [mfd_pkg::S_DATA_W-1:0]  s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mfd_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [mfd_pkg::KIND_W-1:0]    m_tuser,
	input logic                          m_tlast
);

	logic [2:0] st;
	logic       only_status;

	assign st          = m_tdata[38:36];
	assign only_status = (st == mfd_pkg::ST_EMPTY) || (st == mfd_pkg::ST_SKIPPED) ||
	                     (st == mfd_pkg::ST_RAISED) || (st == mfd_pkg::ST_NONE);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && only_status |-> m_tuser == mfd_pkg::K_NONE && m_tdata[35:0] == 36'd0)
		else $error("status-only word carries payload");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && only_status |-> m_tlast)
		else $error("status-only word is not last of frame");

	a_plain_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == mfd_pkg::K_FB_ID || m_tuser == mfd_pkg::K_FB_CODE ||
		m_tuser == mfd_pkg::K_INSTR) |-> m_tdata[2:0] == 3'd0 && !m_tdata[35]
		&& st == mfd_pkg::ST_WRITTEN)
		else $error("non-slot write carries slot or scale");

	a_range_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == mfd_pkg::ST_RANGE |-> m_tdata[2:0] == 3'd0)
		else $error("out of range write has nonzero slot");

endmodule

bind motor_feedback_frame_decoder_core mfd_checker u_mfd_checker (.*);
